FILE: sv/lss_pkg.sv
// shared constants, payload beats, controller commands and status for the sieve block
`timescale 1ns / 1ps

package lss_pkg;

  // table geometry
  localparam int N_MAX    = 4096;
  localparam int IDX_W    = $clog2(N_MAX);
  localparam int VAL_W    = 12;
  localparam int LIMIT_W  = 13;
  localparam int PL_DEPTH = 564;
  localparam int CNT_W    = 10;
  localparam int PROD_W   = 2 * VAL_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(N_MAX);
  localparam logic [IDX_W-1:0]   FIRST_PRIME = IDX_W'(2);

  // request codes
  localparam logic REQ_RUN   = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] factor_index;
    logic [CNT_W-1:0] prime_position;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0] prime_count;
    logic [VAL_W-1:0] smallest_factor;
    logic [VAL_W-1:0] nth_prime;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_FETCH_I,
    S_TEST_I,
    S_FETCH_P,
    S_MUL,
    S_MARK,
    S_QUERY
  } state_t;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic run_init;
    logic test_i;
    logic mul;
    logic mark_wr;
    logic next_i;
    logic q_start;
    logic q_out;
    logic run_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic i_done;
    logic j_done;
    logic brk;
  } dp_status_t;

endpackage

FILE: sv/linear_sieve_smallest_factor.sv
// top level of the linear sieve smallest-factor block
`timescale 1ns / 1ps

// Linear (Euler) sieve with smallest-factor table and prime list.
// Input beat: start is sampled while busy is low; in_data.req_type selects a
// run (sieve 2..min(limit,4096)-1) or query (factor_index, prime_position).
// Result beat: out_valid pulses for one cycle with out_data; the receiver
// cannot hold it off and the block never needs it to.
// Configuration: cfg_we writes cfg_wdata into limit; write it only while idle.
// Query: busy only in S_QUERY, whose command registers the result strobe.
// Run: the factor table is first cleared, one entry a cycle; then each
// integer has its table entry read (S_FETCH_I) and tested (S_TEST_I), and
// each listed prime tried is fetched (S_FETCH_P), multiplied (S_MUL) and
// compared or marked (S_MARK), until a break or the prime list runs out.
// The length of a run is set by the factor table (one read port and one
// write port, one access each a cycle) and the sequential prime walk.
// The run beat reports the prime count with zero factor fields.
// Reset: limit returns to 4096 and the prime count to zero; queries return
// zero factors until the first run has cleared the table.
module linear_sieve_smallest_factor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  lss_pkg::in_t                in_data,
  output logic                        out_valid,
  output lss_pkg::out_t               out_data,
  input  logic                        cfg_we,
  input  logic [lss_pkg::LIMIT_W-1:0] cfg_wdata
);
  import lss_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  lss_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_req (in_data.req_type),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath with both memories
  lss_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // a query beat makes the block busy in S_QUERY, which registers the result beat
  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.req_type == REQ_QUERY)) |=> busy ##1 out_valid)
    else $error("query result not on time");

endmodule

FILE: sv/lss_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module lss_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/lss_ctrl.sv
// sequencer for table clear, sieve walk and query
`timescale 1ns / 1ps

module lss_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_req,
  input  lss_pkg::dp_status_t status,
  output logic               busy,
  output lss_pkg::ctrl_cmd_t cmd
);
  import lss_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_req == REQ_QUERY) begin
            cmd.q_start = 1'b1;
            state_nxt   = S_QUERY;
          end else begin
            cmd.clr_init = 1'b1;
            state_nxt    = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          cmd.run_init = 1'b1;
          state_nxt    = S_FETCH_I;
        end
      end
      S_FETCH_I: begin
        if (status.i_done) begin
          cmd.run_out = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_TEST_I;
        end
      end
      S_TEST_I: begin
        cmd.test_i = 1'b1;
        state_nxt  = S_FETCH_P;
      end
      S_FETCH_P: begin
        if (status.j_done) begin
          cmd.next_i = 1'b1;
          state_nxt  = S_FETCH_I;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        if (status.brk) begin
          cmd.next_i = 1'b1;
          state_nxt  = S_FETCH_I;
        end else begin
          cmd.mark_wr = 1'b1;
          state_nxt   = S_FETCH_P;
        end
      end
      S_QUERY: begin
        cmd.q_out = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/lss_dpath.sv
// sieve datapath: limit register, counters, multiplier, factor table and prime list
`timescale 1ns / 1ps

module lss_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lss_pkg::in_t                  in_data,
  input  logic                          cfg_we,
  input  logic [lss_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  lss_pkg::ctrl_cmd_t            cmd,
  output lss_pkg::dp_status_t           status,
  output logic                          out_valid,
  output lss_pkg::out_t                 out_data
);
  import lss_pkg::*;

  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic [LIMIT_W-1:0] bound;
  logic [LIMIT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic [VAL_W-1:0]   f_r, f_nxt;
  logic [VAL_W-1:0]   p_r, p_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               ran_r, ran_nxt;
  logic               fok_r, fok_nxt;
  logic               pok_r, pok_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               ft_we;
  logic [IDX_W-1:0]   ft_waddr;
  logic [VAL_W-1:0]   ft_wdata;
  logic [IDX_W-1:0]   ft_raddr;
  logic [VAL_W-1:0]   ft_rdata;
  logic               pl_we;
  logic [CNT_W-1:0]   pl_waddr;
  logic [VAL_W-1:0]   pl_wdata;
  logic [CNT_W-1:0]   pl_raddr;
  logic [VAL_W-1:0]   pl_rdata;

  // factor table and prime list
  lss_ram #(.WIDTH(VAL_W), .DEPTH(N_MAX)) u_factor_ram (
    .clk   (clk),
    .we    (ft_we),
    .waddr (ft_waddr),
    .wdata (ft_wdata),
    .raddr (ft_raddr),
    .rdata (ft_rdata)
  );

  lss_ram #(.WIDTH(VAL_W), .DEPTH(PL_DEPTH)) u_prime_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  // effective bound saturates at the table size
  assign bound = (limit_r > LIMIT_W'(N_MAX)) ? LIMIT_W'(N_MAX) : limit_r;

  // status back to the controller
  always_comb begin
    status.clr_last = (clr_r == '1);
    status.i_done   = (i_r >= bound);
    status.j_done   = (j_r == cnt_r);
    status.brk      = (prod_r >= PROD_W'(bound)) || (p_r > f_r);
  end

  // next values and memory port steering
  always_comb begin
    limit_nxt     = limit_r;
    i_nxt         = i_r;
    cnt_nxt       = cnt_r;
    j_nxt         = j_r;
    clr_nxt       = clr_r;
    f_nxt         = f_r;
    p_nxt         = p_r;
    prod_nxt      = prod_r;
    ran_nxt       = ran_r;
    fok_nxt       = fok_r;
    pok_nxt       = pok_r;
    out_valid_nxt = cmd.q_out | cmd.run_out;
    out_data_nxt  = out_data_r;

    ft_we    = 1'b0;
    ft_waddr = clr_r;
    ft_wdata = '0;
    ft_raddr = i_r[IDX_W-1:0];
    pl_we    = 1'b0;
    pl_waddr = cnt_r;
    pl_wdata = i_r[VAL_W-1:0];
    pl_raddr = j_r;

    if (cfg_we) begin
      limit_nxt = cfg_wdata;
    end

    // clearing sweep
    if (cmd.clr_init) begin
      clr_nxt = '0;
    end
    if (cmd.clr_step) begin
      ft_we   = 1'b1;
      clr_nxt = clr_r + 1'b1;
    end

    if (cmd.run_init) begin
      i_nxt   = LIMIT_W'(FIRST_PRIME);
      cnt_nxt = '0;
      ran_nxt = 1'b1;
    end

    // unmarked integer is prime: self factor and append to list
    if (cmd.test_i) begin
      j_nxt = '0;
      if (ft_rdata == '0) begin
        ft_we    = 1'b1;
        ft_waddr = i_r[IDX_W-1:0];
        ft_wdata = i_r[VAL_W-1:0];
        pl_we    = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        f_nxt    = i_r[VAL_W-1:0];
      end else begin
        f_nxt = ft_rdata;
      end
    end

    // product of i and the listed prime
    if (cmd.mul) begin
      p_nxt    = pl_rdata;
      prod_nxt = PROD_W'(i_r[VAL_W-1:0]) * PROD_W'(pl_rdata);
    end

    // mark the composite with its smallest factor
    if (cmd.mark_wr) begin
      ft_we    = 1'b1;
      ft_waddr = prod_r[IDX_W-1:0];
      ft_wdata = p_r;
      j_nxt    = j_r + 1'b1;
    end

    if (cmd.next_i) begin
      i_nxt = i_r + 1'b1;
    end

    // query reads and range qualifiers
    if (cmd.q_start) begin
      ft_raddr = in_data.factor_index;
      pl_raddr = in_data.prime_position;
      fok_nxt  = ran_r && (in_data.factor_index >= FIRST_PRIME)
                 && (LIMIT_W'(in_data.factor_index) < bound);
      pok_nxt  = (in_data.prime_position < cnt_r);
    end

    // result beat
    if (cmd.q_out) begin
      out_data_nxt.prime_count     = cnt_r;
      out_data_nxt.smallest_factor = fok_r ? ft_rdata : '0;
      out_data_nxt.nth_prime       = pok_r ? pl_rdata : '0;
    end
    if (cmd.run_out) begin
      out_data_nxt.prime_count     = cnt_r;
      out_data_nxt.smallest_factor = '0;
      out_data_nxt.nth_prime       = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_RST;
      cnt_r       <= '0;
      ran_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      cnt_r       <= cnt_nxt;
      ran_r       <= ran_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    clr_r      <= clr_nxt;
    f_r        <= f_nxt;
    p_r        <= p_nxt;
    prod_r     <= prod_nxt;
    fok_r      <= fok_nxt;
    pok_r      <= pok_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // prime list never overflows its storage
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(PL_DEPTH))
    else $error("prime count beyond list depth");

  // composite marks stay inside the sieved range
  a_mark_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mark_wr |-> (prod_r < PROD_W'(bound)) && (p_r <= f_r))
    else $error("mark outside sieve range");

  // a result beat only follows a result command
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.q_out || cmd.run_out))
    else $error("result beat without command");

endmodule

FILE: dv/tb_top.sv
// self-checking testbench for the linear sieve smallest-factor block
`timescale 1ns / 1ps

module tb_top;
  import lss_pkg::*;

  localparam int CALM_FIRST = 60;
  localparam int CALM_LAST  = 85;
  localparam int RAND_BEATS = 80;
  localparam int SETTLE_CYC = 40;

  typedef enum logic [1:0] {
    PLAN_BEAT,
    PLAN_CFG,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t          kind;
    in_t                 beat;
    logic [LIMIT_W-1:0]  limit_val;
  } plan_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_t                in_data;
  logic               out_valid;
  out_t               out_data;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;

  // predicted block state
  logic [VAL_W-1:0]   sieve_factor [0:N_MAX-1];
  logic [VAL_W-1:0]   sieve_primes [0:PL_DEPTH-1];
  int unsigned        sieve_count;
  logic [LIMIT_W-1:0] sieve_limit;

  plan_t       beat_plan_q[$];
  out_t        answers_q[$];
  int unsigned n_driven;
  int unsigned n_accepted;
  int unsigned n_checked;
  int unsigned n_fail;
  int unsigned n_runs_seen;
  int unsigned n_queries_seen;
  int unsigned n_limit_writes;
  int unsigned n_planned_runs;
  int unsigned n_planned_beats;
  int unsigned cycle_count;
  int unsigned cycle_budget;

  linear_sieve_smallest_factor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #6 clk = ~clk;

  // sieve bound saturates at the table size
  function automatic int unsigned bound_of(logic [LIMIT_W-1:0] lim);
    return (lim > N_MAX) ? N_MAX : int'(lim);
  endfunction

  // clear the table, then mark each composite once with its smallest prime
  function automatic void rerun_sieve();
    int unsigned bound;
    int unsigned cnt;
    int unsigned p;
    int unsigned prod;
    bound = bound_of(sieve_limit);
    cnt = 0;
    for (int k = 0; k < N_MAX; k++) sieve_factor[k] = '0;
    for (int unsigned i = 2; i < bound; i++) begin
      if (sieve_factor[i] == '0) begin
        sieve_factor[i] = VAL_W'(i);
        if (cnt < PL_DEPTH) begin
          sieve_primes[cnt] = VAL_W'(i);
          cnt++;
        end
      end
      for (int unsigned j = 0; j < cnt; j++) begin
        p = sieve_primes[j];
        prod = i * p;
        if (prod >= bound || p > sieve_factor[i]) break;
        sieve_factor[prod] = VAL_W'(p);
      end
    end
    sieve_count = cnt;
  endfunction

  // expected result beat for one accepted request
  function automatic out_t sieve_predict(in_t beat);
    out_t ans;
    int unsigned bound;
    ans = '0;
    if (beat.req_type == REQ_RUN) begin
      rerun_sieve();
    end else begin
      bound = bound_of(sieve_limit);
      if (beat.factor_index >= 2 && beat.factor_index < bound)
        ans.smallest_factor = sieve_factor[beat.factor_index];
      if (beat.prime_position < sieve_count)
        ans.nth_prime = sieve_primes[beat.prime_position];
    end
    ans.prime_count = CNT_W'(sieve_count);
    return ans;
  endfunction

  function automatic void check_field(string fname, int unsigned want_v, int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want_v, got_v);
      n_fail++;
    end
  endfunction

  // plan building
  function automatic void add_beat(logic req, int unsigned fidx, int unsigned ppos);
    plan_t ent;
    ent = '0;
    ent.kind = PLAN_BEAT;
    ent.beat.req_type = req;
    ent.beat.factor_index = IDX_W'(fidx);
    ent.beat.prime_position = CNT_W'(ppos);
    beat_plan_q.push_back(ent);
    n_planned_beats++;
    if (req == REQ_RUN) n_planned_runs++;
  endfunction

  function automatic void add_cfg(int unsigned lim);
    plan_t ent;
    ent = '0;
    ent.kind = PLAN_CFG;
    ent.limit_val = LIMIT_W'(lim);
    beat_plan_q.push_back(ent);
    n_limit_writes++;
  endfunction

  function automatic void add_drain();
    plan_t ent;
    ent = '0;
    ent.kind = PLAN_DRAIN;
    beat_plan_q.push_back(ent);
  endfunction

  // factor index: half the time near the sieved range, otherwise anywhere
  function automatic int unsigned pick_index(int unsigned bnd);
    int unsigned top;
    top = (bnd + 8 > N_MAX - 1) ? N_MAX - 1 : bnd + 8;
    if ($urandom_range(1) == 0) return $urandom_range(0, top);
    return $urandom_range(0, N_MAX - 1);
  endfunction

  // prime position: mostly around the expected count, rarely past the list
  function automatic int unsigned pick_position(int unsigned bnd);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return $urandom_range(0, bnd / 3 + 2);
    if (sel < 9) return $urandom_range(0, PL_DEPTH - 1);
    return $urandom_range(0, (1 << CNT_W) - 1);
  endfunction

  // stimulus plan, reset and end of run
  initial begin : stim_proc
    int unsigned n_rand;
    int unsigned n_wide;
    int unsigned pick;
    int unsigned lim;
    int unsigned bnd;
    int unsigned nq;
    bit          drained;

    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    n_driven = 0;
    n_accepted = 0;
    n_checked = 0;
    n_fail = 0;
    n_runs_seen = 0;
    n_queries_seen = 0;
    n_limit_writes = 0;
    n_planned_runs = 0;
    n_planned_beats = 0;
    cycle_count = 0;
    for (int k = 0; k < N_MAX; k++) sieve_factor[k] = '0;
    for (int k = 0; k < PL_DEPTH; k++) sieve_primes[k] = '0;
    sieve_count = 0;
    sieve_limit = LIMIT_RST;

    // queries before any run, then a full run at the reset limit
    add_beat(REQ_QUERY, 0, 0);
    add_beat(REQ_QUERY, N_MAX - 1, PL_DEPTH - 1);
    add_beat(REQ_RUN, 0, 0);
    add_beat(REQ_QUERY, 4093, 0);
    add_beat(REQ_QUERY, N_MAX - 1, PL_DEPTH - 1);
    add_beat(REQ_QUERY, 4094, PL_DEPTH);
    add_beat(REQ_QUERY, 0, (1 << CNT_W) - 1);
    add_beat(REQ_QUERY, 1, 1);
    add_beat(REQ_QUERY, 2, 2);
    // limit above the table size saturates
    add_cfg((1 << LIMIT_W) - 1);
    add_beat(REQ_QUERY, N_MAX - 1, 100);
    add_beat(REQ_RUN, N_MAX - 1, (1 << CNT_W) - 1);
    add_beat(REQ_QUERY, N_MAX - 1, PL_DEPTH - 1);
    // limits of zero and two find nothing
    add_cfg(0);
    add_beat(REQ_RUN, 0, 0);
    add_beat(REQ_QUERY, 2, 0);
    add_cfg(2);
    add_beat(REQ_RUN, 0, 0);
    add_beat(REQ_QUERY, 2, 0);
    // small table, then a wider limit without a new run
    add_cfg(100);
    add_beat(REQ_RUN, 0, 0);
    add_beat(REQ_QUERY, 97, 24);
    add_beat(REQ_QUERY, 99, 25);
    add_cfg(N_MAX);
    add_beat(REQ_QUERY, 200, 24);
    add_beat(REQ_QUERY, 97, 0);

    // random phases: set a limit, usually run, then mostly query the tables
    n_rand = 0;
    n_wide = 0;
    drained = 1'b0;
    while (n_rand < RAND_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 8 && n_wide < 3) begin
        lim = $urandom_range(3000, (1 << LIMIT_W) - 1);
        n_wide++;
      end else if (pick < 12) begin
        lim = $urandom_range(0, 3);
      end else begin
        lim = $urandom_range(4, 400);
      end
      add_cfg(lim);
      bnd = bound_of(LIMIT_W'(lim));
      if ($urandom_range(9) != 0) begin
        add_beat(REQ_RUN, $urandom_range(0, N_MAX - 1), $urandom_range(0, (1 << CNT_W) - 1));
        n_rand++;
      end
      nq = $urandom_range(5, 14);
      for (int q = 0; q < nq; q++) begin
        if ($urandom_range(19) == 0)
          add_beat(REQ_RUN, $urandom_range(0, N_MAX - 1), $urandom_range(0, (1 << CNT_W) - 1));
        else
          add_beat(REQ_QUERY, pick_index(bnd), pick_position(bnd));
        n_rand++;
      end
      if (n_rand > 40 && !drained) begin
        add_drain();
        drained = 1'b1;
      end
    end

    // leave a wide margin over the planned runs and beats
    cycle_budget = 4 * (n_planned_runs * 40000 + n_planned_beats * 64) + 100000;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (beat_plan_q.size() != 0 || n_accepted != n_driven || answers_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);

    $display("checked %0d result beats: %0d sieve runs and %0d queries over %0d limit writes",
             n_checked, n_runs_seen, n_queries_seen, n_limit_writes);
    $display("limits spanned zero, two, small tables, the full table and saturated values");
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // driver: presents planned beats and limit writes at the falling edge
  always @(negedge clk) begin : drive_proc
    logic  next_start;
    logic  next_we;
    logic  hold_off;
    plan_t head;
    if (!rst_n) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      next_start = start && (n_accepted != n_driven);
      next_we = 1'b0;
      if (!next_start && beat_plan_q.size() != 0) begin
        head = beat_plan_q[0];
        case (head.kind)
          PLAN_BEAT: begin
            hold_off = !(n_driven >= CALM_FIRST && n_driven < CALM_LAST) &&
                       ($urandom_range(99) < 38);
            if (!hold_off) begin
              in_data <= head.beat;
              next_start = 1'b1;
              n_driven++;
              void'(beat_plan_q.pop_front());
            end
          end
          PLAN_CFG: begin
            // limit is written only once the block has gone quiet
            if (answers_q.size() == 0 && !busy) begin
              cfg_wdata <= head.limit_val;
              next_we = 1'b1;
              void'(beat_plan_q.pop_front());
            end
          end
          default: begin
            if (answers_q.size() == 0 && !busy) void'(beat_plan_q.pop_front());
          end
        endcase
      end
      start <= next_start;
      cfg_we <= next_we;
    end
  end

  // monitor: checks result beats, tracks limit writes and accepted beats
  always @(posedge clk) begin : watch_proc
    out_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (answers_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time, out_data);
          n_fail++;
        end else begin
          want = answers_q.pop_front();
          check_field("prime_count", want.prime_count, out_data.prime_count);
          check_field("smallest_factor", want.smallest_factor, out_data.smallest_factor);
          check_field("nth_prime", want.nth_prime, out_data.nth_prime);
          n_checked++;
        end
      end
      if (cfg_we) sieve_limit = cfg_wdata;
      if (start && !busy) begin
        answers_q.push_back(sieve_predict(in_data));
        n_accepted++;
        if (in_data.req_type == REQ_RUN) n_runs_seen++;
        else n_queries_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, answers_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

FILE: linear_sieve_smallest_factor.f
sv/lss_pkg.sv
sv/lss_ram.sv
sv/lss_ctrl.sv
sv/lss_dpath.sv
sv/linear_sieve_smallest_factor.sv
dv/tb_top.sv
